FILE: sv/wcm_pkg.sv
`timescale 1ns / 1ps
package wcm_pkg;

   localparam int MAX_LEN = 255;
   localparam int PLEN_W  = $clog2(MAX_LEN + 1);
   localparam int TLEN_W  = $clog2(MAX_LEN + 2);

   localparam logic [PLEN_W-1:0] PLEN_FULL = PLEN_W'(MAX_LEN);
   localparam logic [TLEN_W-1:0] TLEN_LAST = TLEN_W'(MAX_LEN);
   localparam logic [TLEN_W-1:0] TLEN_OVER = TLEN_W'(MAX_LEN + 1);

   localparam logic [7:0] STAR_BYTE = 8'h2A;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_APPEND  = 2'd1,
      OP_TEXT    = 2'd2,
      OP_RESTART = 2'd3
   } op_type;

   // What a wave does to each cell it passes.
   typedef enum logic [2:0] {
      KIND_HOLD    = 3'd0,
      KIND_TEXT    = 3'd1,
      KIND_RESTART = 3'd2,
      KIND_APPEND  = 3'd3,
      KIND_CLEAR   = 3'd4
   } kind_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] data;
      logic       new_bit;   // row bit at the cell's left edge, after this item
      logic       old_bit;   // same bit before this item
      logic       ovf;
      logic       too_long;
   } tok_type;

endpackage

FILE: sv/wcm_cell.sv
`timescale 1ns / 1ps
module wcm_cell
   import wcm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    adv,
   input  tok_type tok_i,
   output tok_type tok_o
);

   tok_type    out_ff, out_in;
   logic       active_ff, active_in;
   logic [7:0] pat_ff, pat_in;
   logic       r_ff, r_in;
   logic       take;

   assign take  = adv & tok_i.valid;
   assign tok_o = out_ff;

   always_comb begin
      out_in         = tok_i;
      out_in.old_bit = r_ff;
      active_in      = active_ff;
      pat_in         = pat_ff;
      r_in           = r_ff;
      case (tok_i.kind)
         KIND_TEXT: begin
            if (active_ff) begin
               if (pat_ff == STAR_BYTE) begin
                  out_in.new_bit = tok_i.new_bit | r_ff;
               end else begin
                  out_in.new_bit = tok_i.old_bit & (pat_ff == tok_i.data);
               end
               r_in = out_in.new_bit;
            end
         end
         KIND_RESTART: begin
            if (active_ff) begin
               out_in.new_bit = tok_i.new_bit & (pat_ff == STAR_BYTE);
               r_in           = out_in.new_bit;
            end
         end
         KIND_APPEND: begin
            if (active_ff) begin
               out_in.new_bit = tok_i.new_bit & (pat_ff == STAR_BYTE);
               r_in           = out_in.new_bit;
            end else begin
               // first free cell: capture the byte, then act as a restart
               pat_in         = tok_i.data;
               active_in      = 1'b1;
               out_in.new_bit = tok_i.new_bit & (tok_i.data == STAR_BYTE);
               r_in           = out_in.new_bit;
               out_in.kind    = KIND_RESTART;
            end
         end
         KIND_CLEAR: begin
            active_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff    <= '0;
         active_ff <= 1'b0;
      end else if (adv) begin
         out_ff <= out_in;
         if (tok_i.valid) begin
            active_ff <= active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pat_ff <= pat_in;
         r_ff   <= r_in;
      end
   end

endmodule

FILE: sv/wcm_head.sv
`timescale 1ns / 1ps
module wcm_head
   import wcm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic       req_valid,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_data_byte,
   output tok_type    tok_o
);

   logic [PLEN_W-1:0] plen_ff, plen_in;
   logic [TLEN_W-1:0] tlen_ff, tlen_in;
   logic              ovf_ff, ovf_in;
   logic              row0_ff, row0_in;

   always_comb begin
      plen_in = plen_ff;
      tlen_in = tlen_ff;
      ovf_in  = ovf_ff;
      row0_in = row0_ff;

      tok_o          = '0;
      tok_o.valid    = req_valid;
      tok_o.kind     = KIND_RESTART;
      tok_o.data     = req_data_byte;
      tok_o.new_bit  = 1'b1;
      tok_o.old_bit  = row0_ff;

      case (op_type'(req_operation))
         OP_CLEAR: begin
            plen_in    = '0;
            ovf_in     = 1'b0;
            tlen_in    = '0;
            row0_in    = 1'b1;
            tok_o.kind = KIND_CLEAR;
         end
         OP_APPEND: begin
            tlen_in = '0;
            row0_in = 1'b1;
            if (ovf_ff || plen_ff == PLEN_FULL) begin
               ovf_in = 1'b1;
            end else begin
               plen_in    = plen_ff + 1'b1;
               tok_o.kind = KIND_APPEND;
            end
         end
         OP_TEXT: begin
            tok_o.new_bit = 1'b0;
            if (tlen_ff > TLEN_LAST) begin
               tok_o.kind     = KIND_HOLD;
               tok_o.too_long = 1'b1;
            end else if (tlen_ff == TLEN_LAST) begin
               tlen_in        = TLEN_OVER;
               tok_o.kind     = KIND_HOLD;
               tok_o.too_long = 1'b1;
            end else begin
               tlen_in    = tlen_ff + 1'b1;
               row0_in    = 1'b0;
               tok_o.kind = KIND_TEXT;
            end
         end
         OP_RESTART: begin
            tlen_in = '0;
            row0_in = 1'b1;
         end
         default: begin
         end
      endcase

      tok_o.ovf = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= '0;
         tlen_ff <= '0;
         ovf_ff  <= 1'b0;
         row0_ff <= 1'b1;
      end else if (take) begin
         plen_ff <= plen_in;
         tlen_ff <= tlen_in;
         ovf_ff  <= ovf_in;
         row0_ff <= row0_in;
      end
   end

endmodule

FILE: sv/wildcard_component_matcher.sv
`timescale 1ns / 1ps
// Channel   Ports                                                  Direction
// request   req_valid/req_ready, req_operation, req_data_byte      in
// response  rsp_valid/rsp_ready, rsp_matched,                      out
//           rsp_pattern_overflow, rsp_text_too_long
//
// Takes one transfer per cycle while no result is held on the response side;
// each item's wave crosses the output registers of all MAX_LEN chain cells.
// Reset clears the head counters, every cell's valid and in-use bits; the
// pattern bytes stay undefined until written and need no clearing pass.
// A result held on the response side freezes the whole chain and the request side.
module wildcard_component_matcher
   import wcm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_matched,
   output logic       rsp_pattern_overflow,
   output logic       rsp_text_too_long
);

   // links[j] enters cell j; links[MAX_LEN] is the output register of the last cell
   tok_type links [0:MAX_LEN];
   logic    adv;

   // advance the whole chain unless the finished result waits at the end
   assign adv       = !links[MAX_LEN].valid || rsp_ready;
   assign req_ready = adv;

   // track pattern length, text length and flags; build the wave for each item
   wcm_head u_head (
      .clock         (clock),
      .reset         (reset),
      .take          (req_valid & adv),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_data_byte (req_data_byte),
      .tok_o         (links[0])
   );

   // cell j holds pattern byte j and row bit j+1; cells past the pattern
   // length pass the row bit through, so the chain end carries the match bit
   for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
      wcm_cell u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .tok_i (links[g]),
         .tok_o (links[g+1])
      );
   end

   // drop the match whenever either flag is up
   assign rsp_valid            = links[MAX_LEN].valid;
   assign rsp_matched          = links[MAX_LEN].new_bit & ~links[MAX_LEN].ovf
                                 & ~links[MAX_LEN].too_long;
   assign rsp_pattern_overflow = links[MAX_LEN].ovf;
   assign rsp_text_too_long    = links[MAX_LEN].too_long;

endmodule
